### rtl/fms_pkg.sv
package fms_pkg;

	localparam int TIME_BITS = 40;
	localparam int TIME_OUT_BITS = 40;
	localparam int SAMPLES_PER_FRAME = 1152;
	localparam int RATE_HZ = 44100;
	localparam int FRAME_TIME_US = (SAMPLES_PER_FRAME * 1000000) / RATE_HZ;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [3:0] SYNC_NIBBLE = 4'hF;
	localparam logic [1:0] LAYER3_CODE = 2'b01;
	localparam logic [1:0] RATE_44K1 = 2'b00;
	localparam logic [3:0] BR_FREE = 4'h0;
	localparam logic [3:0] BR_BAD = 4'hF;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_SYNC = 3'd1;
	localparam logic [2:0] ST_CRC = 3'd2;
	localparam logic [2:0] ST_RATE = 3'd3;
	localparam logic [2:0] ST_BITRATE = 3'd4;

	localparam logic [8:0] KBPS_TABLE [16] = '{
		9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
	};

	// 144 * kbps * 1000 / 44100, truncated
	localparam logic [10:0] LEN_TABLE [16] = '{
		11'd0, 11'd104, 11'd130, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313, 11'd365,
		11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd0
	};

	typedef struct packed {
		logic        header_done;
		logic [2:0]  header_status;
		logic        in_frame;
		logic        frame_last;
		logic [8:0]  bitrate_kbps;
		logic [1:0]  channel_mode;
		logic        padded;
		logic [10:0] frame_length;
	} fms_rec_t;

endpackage

### rtl/fms_if.sv
interface fms_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface fms_result_if;
	logic        valid;
	logic        ready;
	logic        header_done;
	logic [2:0]  header_status;
	logic        in_frame;
	logic        frame_last;
	logic [8:0]  bitrate_kbps;
	logic [1:0]  channel_mode;
	logic        padded;
	logic [10:0] frame_length;
	logic [39:0] time_us;

	modport source (output valid, output header_done, output header_status,
		output in_frame, output frame_last, output bitrate_kbps, output channel_mode,
		output padded, output frame_length, output time_us, input ready);
	modport sink (input valid, input header_done, input header_status,
		input in_frame, input frame_last, input bitrate_kbps, input channel_mode,
		input padded, input frame_length, input time_us, output ready);
endinterface

### rtl/fms_front.sv
module fms_front
	import fms_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	fms_byte_if.sink stream,
	output logic     push_valid,
	input  logic     push_ready,
	output fms_rec_t push_rec
);

	localparam logic PH_HEADER = 1'b0;
	localparam logic PH_BODY = 1'b1;

	logic        phase_q, phase_d;
	logic [23:0] hdr_q, hdr_d;
	logic [10:0] idx_q, idx_d;
	logic [10:0] len_q, len_d;
	logic [8:0]  kbps_q, kbps_d;
	logic [1:0]  mode_q, mode_d;
	logic        pad_q, pad_d;

	logic [7:0]  b0, b1, b2;
	logic [3:0]  br_idx;
	logic [11:0] idx_inc;
	logic        done, inf, last;
	logic [2:0]  status;

	assign b0 = hdr_q[23:16];
	assign b1 = hdr_q[15:8];
	assign b2 = hdr_q[7:0];
	assign br_idx = b2[7:4];
	assign idx_inc = {1'b0, idx_q} + 12'd1;

	always_comb begin
		phase_d = phase_q;
		hdr_d = hdr_q;
		idx_d = idx_q;
		len_d = len_q;
		kbps_d = kbps_q;
		mode_d = mode_q;
		pad_d = pad_q;
		done = 1'b0;
		inf = 1'b0;
		last = 1'b0;
		status = ST_OK;
		case (phase_q)
			PH_HEADER: begin
				if (idx_q < 11'd3) begin
					hdr_d = {hdr_q[15:0], stream.data_byte};
					idx_d = idx_inc[10:0];
				end else begin
					done = 1'b1;
					idx_d = '0;
					hdr_d = '0;
					if (b0 != SYNC_BYTE || b1[7:4] != SYNC_NIBBLE || !b1[3]
						|| b1[2:1] != LAYER3_CODE) begin
						status = ST_SYNC;
					end else if (!b1[0]) begin
						status = ST_CRC;
					end else if (b2[3:2] != RATE_44K1) begin
						status = ST_RATE;
					end else if (br_idx == BR_FREE || br_idx == BR_BAD) begin
						status = ST_BITRATE;
					end else begin
						kbps_d = KBPS_TABLE[br_idx];
						pad_d = b2[1];
						mode_d = stream.data_byte[7:6];
						len_d = LEN_TABLE[br_idx] + {10'd0, b2[1]};
						phase_d = PH_BODY;
						idx_d = 11'd4;
						inf = 1'b1;
					end
				end
			end
			PH_BODY: begin
				inf = 1'b1;
				if (idx_inc >= {1'b0, len_q}) begin
					last = 1'b1;
					phase_d = PH_HEADER;
					idx_d = '0;
				end else begin
					idx_d = idx_inc[10:0];
				end
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
	end

	assign stream.ready = push_ready;
	assign push_valid = stream.valid;

	always_comb begin
		push_rec.header_done = done;
		push_rec.header_status = status;
		push_rec.in_frame = inf;
		push_rec.frame_last = last;
		push_rec.bitrate_kbps = kbps_d;
		push_rec.channel_mode = mode_d;
		push_rec.padded = pad_d;
		push_rec.frame_length = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_q <= '0;
			idx_q <= '0;
			len_q <= '0;
			kbps_q <= '0;
			mode_q <= '0;
			pad_q <= 1'b0;
		end else if (stream.valid && push_ready) begin
			phase_q <= phase_d;
			hdr_q <= hdr_d;
			idx_q <= idx_d;
			len_q <= len_d;
			kbps_q <= kbps_d;
			mode_q <= mode_d;
			pad_q <= pad_d;
		end
	end

endmodule

### rtl/fms_queue.sv
module fms_queue
	import fms_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  fms_rec_t push_rec,
	output logic     pop_valid,
	input  logic     pop_ready,
	output fms_rec_t pop_rec
);

	logic [1:0] count_q;
	fms_rec_t   slot0_q, slot1_q;
	logic       push, pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_rec = slot0_q;
	assign push = push_valid && push_ready;
	assign pop = pop_ready && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		case (count_q)
			2'd0: begin
				if (push) begin
					slot0_q <= push_rec;
				end
			end
			2'd1: begin
				if (push && pop) begin
					slot0_q <= push_rec;
				end else if (push) begin
					slot1_q <= push_rec;
				end
			end
			2'd2: begin
				if (pop) begin
					slot0_q <= slot1_q;
				end
				if (pop && push) begin
					slot1_q <= push_rec;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/fms_back.sv
module fms_back
	import fms_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  fms_rec_t      pop_rec,
	fms_result_if.source  result
);

	logic                 out_valid_q;
	fms_rec_t             out_rec_q;
	logic [TIME_BITS-1:0] time_q;
	logic                 take;

	assign pop_ready = !out_valid_q || result.ready;
	assign take = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			time_q <= '0;
		end else begin
			if (pop_ready) begin
				out_valid_q <= pop_valid;
			end
			if (take && pop_rec.frame_last) begin
				time_q <= time_q + TIME_BITS'(FRAME_TIME_US);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_rec_q <= pop_rec;
		end
	end

	assign result.valid = out_valid_q;
	assign result.header_done = out_rec_q.header_done;
	assign result.header_status = out_rec_q.header_status;
	assign result.in_frame = out_rec_q.in_frame;
	assign result.frame_last = out_rec_q.frame_last;
	assign result.bitrate_kbps = out_rec_q.bitrate_kbps;
	assign result.channel_mode = out_rec_q.channel_mode;
	assign result.padded = out_rec_q.padded;
	assign result.frame_length = out_rec_q.frame_length;
	assign result.time_us = TIME_OUT_BITS'(time_q);

endmodule

### rtl/mp3_frame_splitter.sv
// channel  dir  payload                                          transfer
// stream   in   data_byte[7:0]                                   valid & ready
// result   out  header_done, header_status, in_frame,            valid & ready
//               frame_last, bitrate_kbps, channel_mode, padded,
//               frame_length, time_us[39:0]
//
// One byte per cycle sustained while result does not stall; a result is registered in a queue
// slot and then in the output register after its byte transfer.
// The front classifies each byte combinationally (header checks, length table lookup).
// A two-entry queue sits between front and back; the back owns the time adder and
// the output register. Stalls on result fill the queue and then drop stream.ready.
// Asynchronous reset arst_n returns to header collection with control state and time cleared.
module mp3_frame_splitter
	import fms_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	fms_byte_if.sink     stream,
	fms_result_if.source result
);

	logic     push_valid, push_ready;
	logic     pop_valid, pop_ready;
	fms_rec_t push_rec, pop_rec;

	fms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_rec   (push_rec)
	);

	fms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_rec   (push_rec),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_rec    (pop_rec)
	);

	fms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_rec   (pop_rec),
		.result    (result)
	);

	a_last_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.frame_last |-> result.in_frame)
		else $error("frame_last without in_frame");

	a_status_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.header_done |-> result.header_status == ST_OK)
		else $error("status set on non-header byte");

	a_ok_opens_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.header_done && result.header_status == ST_OK
		|-> result.in_frame)
		else $error("accepted header not marked in frame");

	a_stall_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> pop_valid)
		else $error("stream stalled with empty queue");

endmodule
